// File: design/lpg_pkg.sv
// ----------------------------------------------------------------------------
// lpg_pkg
// Shared types and constants for the lawnmower path generator: register
// indexes, reset values, field widths and the controller/datapath bundles.
// ----------------------------------------------------------------------------
package lpg_pkg;

    // field widths
    localparam int LEN_W   = 24;   // length and stripe width registers
    localparam int HALF_W  = 23;   // half lengths
    localparam int TRIG_W  = 16;   // Q1.14 bearing terms
    localparam int COORD_W = 32;   // coordinates in and out
    localparam int PNUM_W  = 6;    // waypoint number
    localparam int IDX_W   = 3;    // configuration register index
    localparam int ACC_W   = 30;   // stripe offset accumulator
    localparam int OFS_W   = 25;   // offset from the centre before rotation
    localparam int PROD_W  = OFS_W + TRIG_W;  // one rotation product
    localparam int SUM_W   = PROD_W + 1;      // sum of two products
    localparam int FRAC_W  = 14;              // Q1.14 fraction bits
    localparam int ROT_W   = SUM_W - FRAC_W;  // rotated offset

    localparam int MAX_WAYPOINTS_DEF = 64;

    // configuration register indexes
    localparam logic [IDX_W-1:0] REG_X_LENGTH     = 3'd0;
    localparam logic [IDX_W-1:0] REG_Y_LENGTH     = 3'd1;
    localparam logic [IDX_W-1:0] REG_STRIPE_WIDTH = 3'd2;
    localparam logic [IDX_W-1:0] REG_COS_BEARING  = 3'd3;
    localparam logic [IDX_W-1:0] REG_SIN_BEARING  = 3'd4;

    // reset values
    localparam logic [LEN_W-1:0]         RST_X_LENGTH     = 24'd5120;
    localparam logic [LEN_W-1:0]         RST_Y_LENGTH     = 24'd5120;
    localparam logic [LEN_W-1:0]         RST_STRIPE_WIDTH = 24'd2560;
    localparam logic signed [TRIG_W-1:0] RST_COS_BEARING  = 16'sd16384;
    localparam logic signed [TRIG_W-1:0] RST_SIN_BEARING  = 16'sd0;

    // rounding constant, one half in Q1.14
    localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(8192);

    // configuration seen by the datapath
    typedef struct packed {
        logic [LEN_W-1:0]         x_length;
        logic [LEN_W-1:0]         y_length;
        logic [LEN_W-1:0]         stripe_width;
        logic signed [TRIG_W-1:0] cos_bearing;
        logic signed [TRIG_W-1:0] sin_bearing;
    } t_cfg;

    // controller to datapath
    typedef struct packed {
        logic load;    // capture centre and geometry
        logic setup;   // resolve the truncation flag
        logic step;    // issue the current waypoint
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic gen_last;   // the waypoint being issued is the final one
        logic pipe_busy;  // waypoints still in flight
    } t_status;

endpackage

// File: design/lpg_ctrl.sv
// ----------------------------------------------------------------------------
// lpg_ctrl
// Request sequencer: load, truncation check, one waypoint per cycle, then
// wait for the rotation pipeline to empty.
// ----------------------------------------------------------------------------
module lpg_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  lpg_pkg::t_status i_status,
    output lpg_pkg::t_cmd   o_cmd,
    output logic            o_busy
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SETUP = 2'd1;
    localparam logic [1:0] ST_GEN   = 2'd2;
    localparam logic [1:0] ST_DRAIN = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    // next state and commands
    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_SETUP;
                end
            end
            ST_SETUP: begin
                o_cmd.setup = 1'b1;
                n_state     = ST_GEN;
            end
            ST_GEN: begin
                o_cmd.step = 1'b1;
                if (i_status.gen_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!i_status.pipe_busy) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != ST_IDLE);

endmodule

// File: design/lpg_datapath.sv
// ----------------------------------------------------------------------------
// lpg_datapath
// Stripe walker and rotation pipeline. The walker produces the offset of one
// waypoint per step; three stages rotate it, round it and add the centre.
// ----------------------------------------------------------------------------
module lpg_datapath #(
    parameter int MAX_WAYPOINTS = lpg_pkg::MAX_WAYPOINTS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  lpg_pkg::t_cfg                      i_cfg,
    input  lpg_pkg::t_cmd                      i_cmd,
    input  logic signed [lpg_pkg::COORD_W-1:0] i_center_x,
    input  logic signed [lpg_pkg::COORD_W-1:0] i_center_y,
    output lpg_pkg::t_status                   o_status,
    output logic                               o_valid,
    output logic signed [lpg_pkg::COORD_W-1:0] o_point_x,
    output logic signed [lpg_pkg::COORD_W-1:0] o_point_y,
    output logic [lpg_pkg::PNUM_W-1:0]         o_point_number,
    output logic                               o_last_point,
    output logic                               o_overflow
);

    localparam int COORD_W = lpg_pkg::COORD_W;
    localparam int HALF_W  = lpg_pkg::HALF_W;
    localparam int LEN_W   = lpg_pkg::LEN_W;
    localparam int ACC_W   = lpg_pkg::ACC_W;
    localparam int OFS_W   = lpg_pkg::OFS_W;
    localparam int PROD_W  = lpg_pkg::PROD_W;
    localparam int SUM_W   = lpg_pkg::SUM_W;
    localparam int FRAC_W  = lpg_pkg::FRAC_W;
    localparam int ROT_W   = lpg_pkg::ROT_W;
    localparam int PNUM_W  = lpg_pkg::PNUM_W;
    localparam int POS_W   = ACC_W + 1;
    localparam int EXT_W   = COORD_W + 1;

    // interior stripes at which the path no longer fits in MAX_WAYPOINTS
    localparam int OVF_STRIPES = (MAX_WAYPOINTS - 3) / 2 + 1;
    localparam logic [PNUM_W-1:0] LAST_PNUM = PNUM_W'(MAX_WAYPOINTS - 1);

    // request geometry
    logic signed [COORD_W-1:0] r_cx;
    logic signed [COORD_W-1:0] r_cy;
    logic [HALF_W-1:0]         r_hx;
    logic [HALF_W-1:0]         r_hy;
    logic [LEN_W-1:0]          r_span;
    logic [LEN_W-1:0]          r_w;
    logic                      r_topdown;
    logic                      r_ovf;
    logic signed [lpg_pkg::TRIG_W-1:0] r_cos;
    logic signed [lpg_pkg::TRIG_W-1:0] r_sin;

    // stripe walker
    logic [PNUM_W-1:0] r_p;
    logic              r_side;   // left edge (top-down) or bottom edge (left-right)
    logic [ACC_W-1:0]  r_acc;    // stripe index times stripe width

    logic                    last_stripe;
    logic                    gen_last;
    logic signed [POS_W-1:0] hx_s;
    logic signed [POS_W-1:0] hy_s;
    logic signed [POS_W-1:0] acc_s;
    logic signed [POS_W-1:0] pos;
    logic signed [POS_W-1:0] side_ofs;
    logic [ACC_W-1:0]        ovf_prod;

    // stage registers
    logic                    r_s0_valid, r_s1_valid, r_s2_valid, r_out_valid;
    logic [PNUM_W-1:0]       r_s0_pnum, r_s1_pnum, r_s2_pnum;
    logic                    r_s0_last, r_s1_last, r_s2_last;
    logic signed [OFS_W-1:0] r_s0_dx, r_s0_dy;
    logic signed [PROD_W-1:0] r_s1_xc, r_s1_ys, r_s1_yc, r_s1_xs;
    logic signed [ROT_W-1:0] r_s2_rx, r_s2_ry;
    logic signed [SUM_W-1:0] sum_x, sum_y;
    logic signed [EXT_W-1:0] ext_x, ext_y;
    logic signed [COORD_W-1:0] r_px, r_py;
    logic [PNUM_W-1:0]       r_out_pnum;
    logic                    r_out_last;

    // geometry capture and truncation check
    assign ovf_prod = ACC_W'(r_w) * ACC_W'(OVF_STRIPES);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cx      <= i_center_x;
            r_cy      <= i_center_y;
            r_hx      <= i_cfg.x_length[LEN_W-1:1];
            r_hy      <= i_cfg.y_length[LEN_W-1:1];
            r_w       <= (i_cfg.stripe_width == '0) ? LEN_W'(1) : i_cfg.stripe_width;
            r_topdown <= (i_cfg.x_length >= i_cfg.y_length);
            r_span    <= (i_cfg.x_length >= i_cfg.y_length) ?
                         {i_cfg.y_length[LEN_W-1:1], 1'b0} :
                         {i_cfg.x_length[LEN_W-1:1], 1'b0};
            r_cos     <= i_cfg.cos_bearing;
            r_sin     <= i_cfg.sin_bearing;
        end
        if (i_cmd.setup) begin
            r_ovf <= (ovf_prod < ACC_W'(r_span));
        end
    end

    // current waypoint offset
    assign hx_s  = $signed({{(POS_W-HALF_W){1'b0}}, r_hx});
    assign hy_s  = $signed({{(POS_W-HALF_W){1'b0}}, r_hy});
    assign acc_s = $signed({1'b0, r_acc});
    assign last_stripe = (r_acc != '0) && (r_acc >= ACC_W'(r_span));

    always_comb begin
        if (r_topdown) begin
            pos      = last_stripe ? -hy_s : (hy_s - acc_s);
            side_ofs = r_side ? -hx_s : hx_s;
        end else begin
            pos      = last_stripe ? hx_s : (acc_s - hx_s);
            side_ofs = r_side ? -hy_s : hy_s;
        end
    end

    assign gen_last = r_ovf ? (r_p == LAST_PNUM)
                            : ((r_p != '0) && !r_p[0] && last_stripe);

    // walker: side flips after an even point, stripe advances after an odd one
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_p    <= '0;
            r_side <= 1'b1;
            r_acc  <= '0;
        end else if (i_cmd.step) begin
            r_p <= r_p + PNUM_W'(1);
            if (!r_p[0]) begin
                r_side <= !r_side;
            end else begin
                r_acc <= r_acc + ACC_W'(r_w);
            end
        end
    end

    // pipeline valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid  <= 1'b0;
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s0_valid  <= i_cmd.step;
            r_s1_valid  <= r_s0_valid;
            r_s2_valid  <= r_s1_valid;
            r_out_valid <= r_s2_valid;
        end
    end

    // stage 0: offsets
    always_ff @(posedge i_clk) begin
        r_s0_pnum <= r_p;
        r_s0_last <= gen_last;
        if (r_topdown) begin
            r_s0_dx <= side_ofs[OFS_W-1:0];
            r_s0_dy <= pos[OFS_W-1:0];
        end else begin
            r_s0_dx <= pos[OFS_W-1:0];
            r_s0_dy <= side_ofs[OFS_W-1:0];
        end
    end

    // stage 1: rotation products
    always_ff @(posedge i_clk) begin
        r_s1_pnum <= r_s0_pnum;
        r_s1_last <= r_s0_last;
        r_s1_xc   <= r_s0_dx * r_cos;
        r_s1_ys   <= r_s0_dy * r_sin;
        r_s1_yc   <= r_s0_dy * r_cos;
        r_s1_xs   <= r_s0_dx * r_sin;
    end

    // stage 2: sum, round half up, floor by 2^14
    assign sum_x = SUM_W'(r_s1_xc) + SUM_W'(r_s1_ys) + lpg_pkg::ROUND_HALF;
    assign sum_y = SUM_W'(r_s1_yc) - SUM_W'(r_s1_xs) + lpg_pkg::ROUND_HALF;

    always_ff @(posedge i_clk) begin
        r_s2_pnum <= r_s1_pnum;
        r_s2_last <= r_s1_last;
        r_s2_rx   <= sum_x[SUM_W-1:FRAC_W];
        r_s2_ry   <= sum_y[SUM_W-1:FRAC_W];
    end

    // stage 3: back to the centre with saturation
    assign ext_x = EXT_W'(r_cx) + EXT_W'(r_s2_rx);
    assign ext_y = EXT_W'(r_cy) + EXT_W'(r_s2_ry);

    always_ff @(posedge i_clk) begin
        r_out_pnum <= r_s2_pnum;
        r_out_last <= r_s2_last;
        if (ext_x[EXT_W-1] != ext_x[EXT_W-2]) begin
            r_px <= ext_x[EXT_W-1] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
        end else begin
            r_px <= ext_x[COORD_W-1:0];
        end
        if (ext_y[EXT_W-1] != ext_y[EXT_W-2]) begin
            r_py <= ext_y[EXT_W-1] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
        end else begin
            r_py <= ext_y[COORD_W-1:0];
        end
    end

    assign o_status.gen_last  = gen_last;
    assign o_status.pipe_busy = r_s0_valid | r_s1_valid | r_s2_valid | r_out_valid;

    assign o_valid        = r_out_valid;
    assign o_point_x      = r_px;
    assign o_point_y      = r_py;
    assign o_point_number = r_out_pnum;
    assign o_last_point   = r_out_last;
    assign o_overflow     = r_ovf;

endmodule

// File: design/lawnmower_path_generator.sv
// ----------------------------------------------------------------------------
// lawnmower_path_generator
// Back-and-forth coverage path over a configured rectangle, rotated by the
// configured bearing about the requested centre.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. It yields N
// waypoints, N = min(2 * stripes - 1, MAX_WAYPOINTS), one per clock cycle on
// o_point_valid; busy stays high until the last has left the pipeline.
// The stripe walker issues one waypoint per cycle and a three-stage
// multiply/round/saturate pipeline follows it, so the point count sets the
// time. Results cannot be held off: each is shown for a single cycle.
// Configuration writes are always ready and must only be made while busy is
// low.
module lawnmower_path_generator #(
    parameter int MAX_WAYPOINTS = lpg_pkg::MAX_WAYPOINTS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // request
    input  logic                               start,
    output logic                               busy,
    input  logic signed [lpg_pkg::COORD_W-1:0] i_center_x,
    input  logic signed [lpg_pkg::COORD_W-1:0] i_center_y,
    // configuration
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [lpg_pkg::IDX_W-1:0]          i_cfg_index,
    input  logic [lpg_pkg::LEN_W-1:0]          i_cfg_data,
    // waypoints
    output logic                               o_point_valid,
    output logic signed [lpg_pkg::COORD_W-1:0] o_point_x,
    output logic signed [lpg_pkg::COORD_W-1:0] o_point_y,
    output logic [lpg_pkg::PNUM_W-1:0]         o_point_number,
    output logic                               o_last_point,
    output logic                               o_overflow
);

    localparam int TRIG_W = lpg_pkg::TRIG_W;

    lpg_pkg::t_cfg    r_cfg;
    lpg_pkg::t_cmd    cmd;
    lpg_pkg::t_status status;

    // configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.x_length     <= lpg_pkg::RST_X_LENGTH;
            r_cfg.y_length     <= lpg_pkg::RST_Y_LENGTH;
            r_cfg.stripe_width <= lpg_pkg::RST_STRIPE_WIDTH;
            r_cfg.cos_bearing  <= lpg_pkg::RST_COS_BEARING;
            r_cfg.sin_bearing  <= lpg_pkg::RST_SIN_BEARING;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                lpg_pkg::REG_X_LENGTH:     r_cfg.x_length     <= i_cfg_data;
                lpg_pkg::REG_Y_LENGTH:     r_cfg.y_length     <= i_cfg_data;
                lpg_pkg::REG_STRIPE_WIDTH: r_cfg.stripe_width <= i_cfg_data;
                lpg_pkg::REG_COS_BEARING:  r_cfg.cos_bearing  <= $signed(i_cfg_data[TRIG_W-1:0]);
                lpg_pkg::REG_SIN_BEARING:  r_cfg.sin_bearing  <= $signed(i_cfg_data[TRIG_W-1:0]);
                default: begin
                end
            endcase
        end
    end

    lpg_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (busy)
    );

    lpg_datapath #(
        .MAX_WAYPOINTS (MAX_WAYPOINTS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_cmd          (cmd),
        .i_center_x     (i_center_x),
        .i_center_y     (i_center_y),
        .o_status       (status),
        .o_valid        (o_point_valid),
        .o_point_x      (o_point_x),
        .o_point_y      (o_point_y),
        .o_point_number (o_point_number),
        .o_last_point   (o_last_point),
        .o_overflow     (o_overflow)
    );

`ifndef SYNTH
    // waypoints only leave while a request is in progress
    a_valid_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_point_valid |-> busy)
        else $error("waypoint outside a request");

    // nothing follows the final waypoint
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_point_valid && o_last_point |=> !o_point_valid)
        else $error("waypoint after the final one");

    // waypoints of one path come in back-to-back cycles
    a_no_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_point_valid && !o_last_point |=> o_point_valid)
        else $error("gap inside a path");

    // numbering runs up by one
    a_numbering: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_point_valid && $past(o_point_valid) |->
            o_point_number == $past(o_point_number) + lpg_pkg::PNUM_W'(1))
        else $error("waypoint number skipped");
`endif

endmodule

// File: tb/lawnmower_path_generator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lawnmower_path_generator_tb
// Self-checking bench for the coverage path generator. Each request is
// expanded by a path scoreboard into the waypoints the block must emit for
// the register values in force. Every waypoint strobe is checked against
// them in order. Directed phases cover the register extremes and the corner
// cases, then random phases mix geometry, bearings and centres with random
// gaps on the request and configuration channels.
// ----------------------------------------------------------------------------
module lawnmower_path_generator_tb;

    localparam int COORD_W      = lpg_pkg::COORD_W;
    localparam int LEN_W        = lpg_pkg::LEN_W;
    localparam int TRIG_W       = lpg_pkg::TRIG_W;
    localparam int PNUM_W       = lpg_pkg::PNUM_W;
    localparam int IDX_W        = lpg_pkg::IDX_W;
    localparam int FRAC_W       = lpg_pkg::FRAC_W;

    localparam int MAX_WP       = lpg_pkg::MAX_WAYPOINTS_DEF;
    localparam int N_ITEMS      = 280;
    localparam int STALL_LIMIT  = 1000;
    localparam int DRAIN_CYCLES = 20;
    localparam int MAX_PRINT    = 40;
    localparam int RESET_CYCLES = 12;

    localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};
    localparam longint ROUND_Q14 = 64'sd1 <<< (FRAC_W - 1);

    typedef struct {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic [PNUM_W-1:0]         num;
        logic                      last;
        logic                      ovf;
    } t_waypoint;

    // Path scoreboard: register copy, waypoint expansion and result check
    class t_path_scoreboard;
        logic [LEN_W-1:0]         x_len;
        logic [LEN_W-1:0]         y_len;
        logic [LEN_W-1:0]         stripe_w;
        logic signed [TRIG_W-1:0] cos_b;
        logic signed [TRIG_W-1:0] sin_b;
        t_waypoint                waypoint_q[$];
        int                       errors;

        function new();
            x_len    = lpg_pkg::RST_X_LENGTH;
            y_len    = lpg_pkg::RST_Y_LENGTH;
            stripe_w = lpg_pkg::RST_STRIPE_WIDTH;
            cos_b    = lpg_pkg::RST_COS_BEARING;
            sin_b    = lpg_pkg::RST_SIN_BEARING;
            errors   = 0;
        endfunction

        function int pending();
            return waypoint_q.size();
        endfunction

        // unused indexes are ignored, trig terms keep the low 16 bits
        function void set_reg(logic [IDX_W-1:0] idx, logic [LEN_W-1:0] data);
            case (idx)
                lpg_pkg::REG_X_LENGTH:     x_len    = data;
                lpg_pkg::REG_Y_LENGTH:     y_len    = data;
                lpg_pkg::REG_STRIPE_WIDTH: stripe_w = data;
                lpg_pkg::REG_COS_BEARING:  cos_b    = data[TRIG_W-1:0];
                lpg_pkg::REG_SIN_BEARING:  sin_b    = data[TRIG_W-1:0];
                default: ;
            endcase
        endfunction

        function longint clamp32(longint v);
            if (v > longint'(COORD_MAX))
                return longint'(COORD_MAX);
            if (v < longint'(COORD_MIN))
                return longint'(COORD_MIN);
            return v;
        endfunction

        // expand one accepted request into its waypoints
        function void add_request_path(logic signed [COORD_W-1:0] cx,
                                       logic signed [COORD_W-1:0] cy);
            longint    hx, hy, w, span, inner, n_stripes, n_total, n_emit;
            longint    j, stripe, dx, dy, rx, ry, c, s;
            bit        across, near_side, trunc;
            t_waypoint wp;
            hx        = longint'(x_len >> 1);
            hy        = longint'(y_len >> 1);
            w         = (stripe_w == 0) ? 64'sd1 : longint'(stripe_w);
            c         = longint'(cos_b);
            s         = longint'(sin_b);
            across    = (x_len >= y_len);
            span      = across ? 2 * hy : 2 * hx;
            inner     = (span > 0) ? (span - 1) / w : 0;
            n_stripes = inner + 2;
            n_total   = 2 * n_stripes - 1;
            trunc     = (n_total > MAX_WP);
            n_emit    = trunc ? MAX_WP : n_total;
            for (int p = 0; p < n_emit; p++) begin
                if (p == 0) begin
                    stripe    = 0;
                    near_side = 1'b1;
                end else begin
                    j         = (p - 1) / 2;
                    stripe    = j + (p - 1) % 2;
                    near_side = (j % 2) != 0;
                end
                if (across) begin
                    dy = (stripe >= n_stripes - 1) ? -hy : hy - stripe * w;
                    dx = near_side ? -hx : hx;
                end else begin
                    dx = (stripe >= n_stripes - 1) ? hx : -hx + stripe * w;
                    dy = near_side ? -hy : hy;
                end
                // rotate, round half up, then saturate around the centre
                rx      = (dx * c + dy * s + ROUND_Q14) >>> FRAC_W;
                ry      = (dy * c - dx * s + ROUND_Q14) >>> FRAC_W;
                wp.x    = COORD_W'(clamp32(longint'(cx) + rx));
                wp.y    = COORD_W'(clamp32(longint'(cy) + ry));
                wp.num  = PNUM_W'(p);
                wp.last = (p == n_emit - 1);
                wp.ovf  = trunc;
                waypoint_q.insert(waypoint_q.size(), wp);
            end
        endfunction

        task report(string msg);
            if (errors < MAX_PRINT)
                $display("[%0t] MISMATCH: %s", $realtime, msg);
            errors++;
        endtask

        task check_point(logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y,
                         logic [PNUM_W-1:0] num, logic last, logic ovf);
            t_waypoint wp;
            if (waypoint_q.size() == 0) begin
                report($sformatf("unexpected waypoint num=%0d x=%0d y=%0d", num, x, y));
                return;
            end
            wp = waypoint_q.pop_front();
            if (x !== wp.x)
                report($sformatf("waypoint %0d x=%0d, want %0d", wp.num, x, wp.x));
            if (y !== wp.y)
                report($sformatf("waypoint %0d y=%0d, want %0d", wp.num, y, wp.y));
            if (num !== wp.num)
                report($sformatf("waypoint number %0d, want %0d", num, wp.num));
            if (last !== wp.last)
                report($sformatf("waypoint %0d last=%b, want %b", wp.num, last, wp.last));
            if (ovf !== wp.ovf)
                report($sformatf("waypoint %0d overflow=%b, want %b", wp.num, ovf, wp.ovf));
        endtask
    endclass

    logic                      i_clk          = 1'b0;
    logic                      i_rst_n        = 1'b0;
    logic                      start          = 1'b0;
    logic signed [COORD_W-1:0] i_center_x     = '0;
    logic signed [COORD_W-1:0] i_center_y     = '0;
    logic                      i_cfg_valid    = 1'b0;
    logic [IDX_W-1:0]          i_cfg_index    = '0;
    logic [LEN_W-1:0]          i_cfg_data     = '0;
    logic                      busy;
    logic                      o_cfg_ready;
    logic                      o_point_valid;
    logic signed [COORD_W-1:0] o_point_x;
    logic signed [COORD_W-1:0] o_point_y;
    logic [PNUM_W-1:0]         o_point_number;
    logic                      o_last_point;
    logic                      o_overflow;

    t_path_scoreboard sb;
    int               n_sent      = 0;
    int               stall_count = 0;
    bit               idle_on     = 1'b0;

    lawnmower_path_generator uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_center_x     (i_center_x),
        .i_center_y     (i_center_y),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_point_valid  (o_point_valid),
        .o_point_x      (o_point_x),
        .o_point_y      (o_point_y),
        .o_point_number (o_point_number),
        .o_last_point   (o_last_point),
        .o_overflow     (o_overflow)
    );

    always #5 i_clk = ~i_clk;

    // waypoint monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_point_valid === 1'b1)
            sb.check_point(o_point_x, o_point_y, o_point_number, o_last_point, o_overflow);
    end

    // watchdog: cycles with no transaction on any channel
    always @(posedge i_clk) begin
        if ((start && !busy) || (i_cfg_valid && o_cfg_ready) || o_point_valid === 1'b1)
            stall_count <= 0;
        else
            stall_count <= stall_count + 1;
        if (stall_count >= STALL_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!idle_on || r < 40)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic signed [COORD_W-1:0] rand_coord();
        case ($urandom_range(0, 9))
            0:       return COORD_MAX - COORD_W'($urandom_range(0, 20000));
            1:       return COORD_MIN + COORD_W'($urandom_range(0, 20000));
            default: return $urandom;
        endcase
    endfunction

    function automatic logic signed [TRIG_W-1:0] rand_trig();
        case ($urandom_range(0, 5))
            0:       return TRIG_W'($urandom);
            1:       return $urandom_range(0, 1) ? 16'sh4000 : 16'shC000;
            2:       return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            default: return TRIG_W'($urandom_range(0, 32768)) - 16'sd16384;
        endcase
    endfunction

    // wait until every waypoint is in and the block is idle
    task automatic wait_idle();
        start       <= 1'b0;
        i_cfg_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0 || busy);
    endtask

    // one register write transaction; caller lowers valid after the batch
    task automatic cfg_write(input logic [IDX_W-1:0] idx, input logic [LEN_W-1:0] data);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_cfg_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_reg(idx, data);
    endtask

    // trig terms carry random upper data bits, which must be ignored
    task automatic configure(input logic [LEN_W-1:0] lx, input logic [LEN_W-1:0] ly,
                             input logic [LEN_W-1:0] w,
                             input logic signed [TRIG_W-1:0] c,
                             input logic signed [TRIG_W-1:0] s);
        wait_idle();
        cfg_write(lpg_pkg::REG_X_LENGTH, lx);
        cfg_write(lpg_pkg::REG_Y_LENGTH, ly);
        cfg_write(lpg_pkg::REG_STRIPE_WIDTH, w);
        cfg_write(lpg_pkg::REG_COS_BEARING, {8'($urandom), c});
        cfg_write(lpg_pkg::REG_SIN_BEARING, {8'($urandom), s});
        i_cfg_valid <= 1'b0;
    endtask

    // one request transaction; start stays high across back-to-back requests
    task automatic send_request(input logic signed [COORD_W-1:0] cx,
                                input logic signed [COORD_W-1:0] cy);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start      <= 1'b1;
        i_center_x <= cx;
        i_center_y <= cy;
        do @(posedge i_clk); while (busy);
        sb.add_request_path(cx, cy);
        n_sent++;
    endtask

    // random geometry; each register is written or left as it is
    task automatic random_config();
        logic [LEN_W-1:0] w, lx, ly;
        int               shape;
        shape = $urandom_range(0, 9);
        if (shape == 0) begin
            w  = LEN_W'($urandom);
            lx = LEN_W'($urandom);
            ly = LEN_W'($urandom);
        end else if (shape == 1) begin
            w  = LEN_W'($urandom_range(0, 1));
            lx = LEN_W'($urandom_range(0, 80));
            ly = LEN_W'($urandom_range(0, 80));
        end else begin
            w  = LEN_W'($urandom_range(1, 4000));
            lx = LEN_W'($urandom_range(0, w * 36));
            ly = LEN_W'($urandom_range(0, w * 36));
        end
        wait_idle();
        if ($urandom_range(0, 1)) cfg_write(lpg_pkg::REG_X_LENGTH, lx);
        if ($urandom_range(0, 1)) cfg_write(lpg_pkg::REG_Y_LENGTH, ly);
        if ($urandom_range(0, 1)) cfg_write(lpg_pkg::REG_STRIPE_WIDTH, w);
        if ($urandom_range(0, 1))
            cfg_write(lpg_pkg::REG_COS_BEARING, {8'($urandom), rand_trig()});
        if ($urandom_range(0, 1))
            cfg_write(lpg_pkg::REG_SIN_BEARING, {8'($urandom), rand_trig()});
        if ($urandom_range(0, 7) == 0)
            cfg_write(IDX_W'($urandom_range(int'(lpg_pkg::REG_SIN_BEARING) + 1,
                                            (1 << IDX_W) - 1)),
                      LEN_W'($urandom));
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        int burst;
        sb = new();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset geometry, centre extremes, back-to-back requests
        send_request(0, 0);
        send_request(COORD_MAX, COORD_MAX);
        send_request(COORD_MIN, COORD_MIN);
        send_request(COORD_MAX, COORD_MIN);
        idle_on = 1'b1;

        // zero lengths: edges coincide, three points
        configure(0, 0, 2560, 16'sh4000, 16'sh0000);
        send_request(0, 0);
        send_request(-1, 1);

        // left-right stripes, zero width and with interior columns
        configure(0, 5000, 1000, 16'sh4000, 16'sh0000);
        send_request(1000, -1000);
        configure(3000, 5001, 1000, 16'sh0000, 16'sh4000);
        send_request(-5000, 7000);
        send_request(COORD_MIN, COORD_MAX);

        // zero stripe width behaves as width one
        configure(40, 30, 0, 16'sh4000, 16'sh0000);
        send_request(12345, -54321);

        // just under, just over and far over the waypoint limit, 45 degrees
        configure(3002, 3002, 100, 16'sh2D41, 16'sh2D41);
        send_request(0, 0);
        configure(3102, 3102, 100, 16'sh2D41, 16'sh2D41);
        send_request(-77, 77);
        configure(24'hFFFFFF, 24'hFFFFFF, 1, 16'shC000, 16'sh4000);
        send_request(0, 0);

        // largest lengths and width, bearing outside the unit circle
        configure(24'hFFFFFF, 24'hFFFFFE, 24'hFFFFFF, 16'sh8000, 16'sh7FFF);
        send_request(COORD_MAX, COORD_MIN);
        send_request(COORD_MIN, COORD_MAX);
        send_request(0, 0);

        // left-right path truncated at the limit, negative bearing
        configure(100, 24'hFFFFFF, 1, 16'shC000, 16'shC000);
        send_request(-3, 3);

        // unused register indexes are ignored
        wait_idle();
        for (int k = int'(lpg_pkg::REG_SIN_BEARING) + 1; k < (1 << IDX_W); k++)
            cfg_write(IDX_W'(k), 24'hFFFFFF);
        cfg_write(lpg_pkg::REG_COS_BEARING, 24'hAB4000);
        cfg_write(lpg_pkg::REG_SIN_BEARING, 24'h5AC000);
        cfg_write(lpg_pkg::REG_X_LENGTH, 24'd9000);
        i_cfg_valid <= 1'b0;
        send_request(4096, -4096);

        // random phases
        while (n_sent < N_ITEMS) begin
            idle_on = ($urandom_range(0, 3) != 0);
            random_config();
            burst = $urandom_range(4, 20);
            if (burst > N_ITEMS - n_sent)
                burst = N_ITEMS - n_sent;
            repeat (burst) send_request(rand_coord(), rand_coord());
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
